[hdl/debounced_updown_counter_seg_scan_macros.svh]
// Assertion macros for the debounced up/down counter with display scan.
// Used by the RTL files in this folder; expects a clock named clock and a reset named reset.
`ifndef DEBOUNCED_UPDOWN_COUNTER_SEG_SCAN_MACROS_SVH
`define DEBOUNCED_UPDOWN_COUNTER_SEG_SCAN_MACROS_SVH

// Checked at every rising edge, disabled while reset is high.
`define DUDC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked only when the previous edge was not in reset either.
`define DUDC_ASSERT_SETTLED(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) \
      (!$past(reset) |-> (prop))) else $error(msg);

`endif

[hdl/dudc_pkg.sv]
// Package for the debounced up/down counter with display scan.
// Holds the decimal digit types, scan position codes and the segment decoder; no dependencies.
`timescale 1ns / 1ps

package dudc_pkg;

   localparam int DEBOUNCE_WIDTH = 8;
   localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET = 8'd50;

   // Count digits: the leading digit is count/1000 and reaches 65.
   typedef logic [3:0] bcd_type;
   typedef logic [6:0] thousands_type;
   typedef logic [1:0] scan_pos_type;

   // Decimal form of 65535, loaded when the count wraps down from zero.
   localparam thousands_type WRAP_THOUSANDS = 7'd65;
   localparam bcd_type       WRAP_HUNDREDS  = 4'd5;
   localparam bcd_type       WRAP_TENS      = 4'd3;
   localparam bcd_type       WRAP_UNITS     = 4'd5;
   localparam bcd_type       BCD_NINE       = 4'd9;
   localparam bcd_type       BCD_ZERO       = 4'd0;

   localparam scan_pos_type POS_THOUSANDS = 2'd0;
   localparam scan_pos_type POS_HUNDREDS  = 2'd1;
   localparam scan_pos_type POS_TENS      = 2'd2;
   localparam scan_pos_type POS_UNITS     = 2'd3;

   typedef struct packed {
      logic ms_tick;
      logic down_press_edge;
      logic up_press_edge;
      logic down_pin_low;
      logic up_pin_low;
      logic check_strobe;
      logic scan_strobe;
   } req_item_type;

   // Segments A..G in bits 0..6, decimal point (bit 7) off.
   function automatic logic [7:0] seg_decode(input bcd_type digit);
      logic [7:0] seg;
      case (digit)
         4'd0:    seg = 8'h3F;
         4'd1:    seg = 8'h06;
         4'd2:    seg = 8'h5B;
         4'd3:    seg = 8'h4F;
         4'd4:    seg = 8'h66;
         4'd5:    seg = 8'h6D;
         4'd6:    seg = 8'h7D;
         4'd7:    seg = 8'h07;
         4'd8:    seg = 8'h7F;
         4'd9:    seg = 8'h6F;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

endpackage

[hdl/debounced_updown_counter_seg_scan.sv]
// Debounced up/down counter driving a four-digit multiplexed seven-segment display.
// Accepted requests pass through the input register, then the state update and result register;
// throughput: one transaction per cycle while rsp_stall does not hold the result register.
// Reset (synchronous) clears all state but the input item: count 0, segments off, commons low, debounce 50 ms.
// Depends on dudc_pkg and debounced_updown_counter_seg_scan_macros.svh.
`timescale 1ns / 1ps
`include "debounced_updown_counter_seg_scan_macros.svh"

module debounced_updown_counter_seg_scan #(
   parameter int AGE_WIDTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_ms_tick,
   input  logic        req_down_press_edge,
   input  logic        req_up_press_edge,
   input  logic        req_down_pin_low,
   input  logic        req_up_pin_low,
   input  logic        req_check_strobe,
   input  logic        req_scan_strobe,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_segments,
   output logic [3:0]  rsp_digit_enable_n,
   output logic [15:0] rsp_count_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [dudc_pkg::DEBOUNCE_WIDTH-1:0] csr_debounce_ms
);

   localparam int CMP_WIDTH = (AGE_WIDTH > dudc_pkg::DEBOUNCE_WIDTH) ?
                              AGE_WIDTH : dudc_pkg::DEBOUNCE_WIDTH;

   // Input register.
   logic                   s1_valid_ff, s1_valid_in;
   dudc_pkg::req_item_type s1_item_ff, s1_item_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Block state; the count, segment and digit latches also form the result payload.
   logic [dudc_pkg::DEBOUNCE_WIDTH-1:0] debounce_ff, debounce_in;
   logic                   down_pending_ff, down_pending_in;
   logic                   up_pending_ff, up_pending_in;
   logic [AGE_WIDTH-1:0]   down_age_ff, down_age_in;
   logic [AGE_WIDTH-1:0]   up_age_ff, up_age_in;
   logic [15:0]            count_ff, count_in;
   dudc_pkg::thousands_type thousands_ff, thousands_in;
   dudc_pkg::bcd_type      hundreds_ff, hundreds_in;
   dudc_pkg::bcd_type      tens_ff, tens_in;
   dudc_pkg::bcd_type      units_ff, units_in;
   dudc_pkg::scan_pos_type scan_pos_ff, scan_pos_in;
   logic [7:0]             segment_ff, segment_in;
   logic [3:0]             digit_ff, digit_in;

   logic                   req_accept;
   logic                   advance;
   logic [AGE_WIDTH-1:0]   down_age_tick, up_age_tick;
   logic                   down_fire, up_fire;
   logic                   u9, t9, h9, u0, t0, h0;
   logic [6:0]             shown_digit;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_segments       = segment_ff;
   assign rsp_digit_enable_n = digit_ff;
   assign rsp_count_value    = count_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (req_accept) begin
         s1_valid_in                = 1'b1;
         s1_item_in.ms_tick         = req_ms_tick;
         s1_item_in.down_press_edge = req_down_press_edge;
         s1_item_in.up_press_edge   = req_up_press_edge;
         s1_item_in.down_pin_low    = req_down_pin_low;
         s1_item_in.up_pin_low      = req_up_pin_low;
         s1_item_in.check_strobe    = req_check_strobe;
         s1_item_in.scan_strobe     = req_scan_strobe;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      debounce_in = debounce_ff;
      if (csr_valid && csr_ready) begin
         debounce_in = csr_debounce_ms;
      end
   end

   // Ages, edges and the debounce check.
   always_comb begin
      down_age_tick = down_age_ff;
      up_age_tick   = up_age_ff;
      if (s1_item_ff.ms_tick) begin
         if (down_age_ff != '1) begin
            down_age_tick = down_age_ff + 1'b1;
         end
         if (up_age_ff != '1) begin
            up_age_tick = up_age_ff + 1'b1;
         end
      end
      down_age_in     = s1_item_ff.down_press_edge ? '0 : down_age_tick;
      up_age_in       = s1_item_ff.up_press_edge ? '0 : up_age_tick;
      down_pending_in = down_pending_ff || s1_item_ff.down_press_edge;
      up_pending_in   = up_pending_ff || s1_item_ff.up_press_edge;

      down_fire = s1_item_ff.check_strobe && down_pending_in && s1_item_ff.down_pin_low &&
                  (CMP_WIDTH'(down_age_in) > CMP_WIDTH'(debounce_ff));
      up_fire   = s1_item_ff.check_strobe && up_pending_in && s1_item_ff.up_pin_low &&
                  (CMP_WIDTH'(up_age_in) > CMP_WIDTH'(debounce_ff));
      if (down_fire) begin
         down_pending_in = 1'b0;
      end
      if (up_fire) begin
         up_pending_in = 1'b0;
      end
   end

   // The count is kept in binary and in decimal digits side by side, so the
   // display never needs a divider.
   always_comb begin
      u9 = (units_ff == dudc_pkg::BCD_NINE);
      t9 = (tens_ff == dudc_pkg::BCD_NINE);
      h9 = (hundreds_ff == dudc_pkg::BCD_NINE);
      u0 = (units_ff == dudc_pkg::BCD_ZERO);
      t0 = (tens_ff == dudc_pkg::BCD_ZERO);
      h0 = (hundreds_ff == dudc_pkg::BCD_ZERO);

      count_in     = count_ff;
      thousands_in = thousands_ff;
      hundreds_in  = hundreds_ff;
      tens_in      = tens_ff;
      units_in     = units_ff;
      if (up_fire && !down_fire) begin
         count_in = count_ff + 16'd1;
         if (count_ff == 16'hFFFF) begin
            thousands_in = '0;
            hundreds_in  = dudc_pkg::BCD_ZERO;
            tens_in      = dudc_pkg::BCD_ZERO;
            units_in     = dudc_pkg::BCD_ZERO;
         end else begin
            units_in = u9 ? dudc_pkg::BCD_ZERO : units_ff + 4'd1;
            if (u9) begin
               tens_in = t9 ? dudc_pkg::BCD_ZERO : tens_ff + 4'd1;
            end
            if (u9 && t9) begin
               hundreds_in = h9 ? dudc_pkg::BCD_ZERO : hundreds_ff + 4'd1;
            end
            if (u9 && t9 && h9) begin
               thousands_in = thousands_ff + 7'd1;
            end
         end
      end else if (down_fire && !up_fire) begin
         count_in = count_ff - 16'd1;
         if (count_ff == 16'd0) begin
            thousands_in = dudc_pkg::WRAP_THOUSANDS;
            hundreds_in  = dudc_pkg::WRAP_HUNDREDS;
            tens_in      = dudc_pkg::WRAP_TENS;
            units_in     = dudc_pkg::WRAP_UNITS;
         end else begin
            units_in = u0 ? dudc_pkg::BCD_NINE : units_ff - 4'd1;
            if (u0) begin
               tens_in = t0 ? dudc_pkg::BCD_NINE : tens_ff - 4'd1;
            end
            if (u0 && t0) begin
               hundreds_in = h0 ? dudc_pkg::BCD_NINE : hundreds_ff - 4'd1;
            end
            if (u0 && t0 && h0) begin
               thousands_in = thousands_ff - 7'd1;
            end
         end
      end
   end

   // Display scan of the updated count.
   always_comb begin
      case (scan_pos_ff)
         dudc_pkg::POS_THOUSANDS: shown_digit = thousands_in;
         dudc_pkg::POS_HUNDREDS:  shown_digit = {3'b000, hundreds_in};
         dudc_pkg::POS_TENS:      shown_digit = {3'b000, tens_in};
         dudc_pkg::POS_UNITS:     shown_digit = {3'b000, units_in};
         default:                 shown_digit = '0;
      endcase

      scan_pos_in = scan_pos_ff;
      segment_in  = segment_ff;
      digit_in    = digit_ff;
      if (s1_item_ff.scan_strobe) begin
         scan_pos_in = scan_pos_ff + 2'd1;
         digit_in    = ~(4'b0001 << scan_pos_ff);
         // A leading value above nine leaves the segments as they were.
         if (shown_digit <= 7'(dudc_pkg::BCD_NINE)) begin
            segment_in = dudc_pkg::seg_decode(shown_digit[3:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         debounce_ff     <= dudc_pkg::DEBOUNCE_RESET;
         down_pending_ff <= 1'b0;
         up_pending_ff   <= 1'b0;
         down_age_ff     <= '0;
         up_age_ff       <= '0;
         count_ff        <= '0;
         thousands_ff    <= '0;
         hundreds_ff     <= dudc_pkg::BCD_ZERO;
         tens_ff         <= dudc_pkg::BCD_ZERO;
         units_ff        <= dudc_pkg::BCD_ZERO;
         scan_pos_ff     <= dudc_pkg::POS_THOUSANDS;
         segment_ff      <= '0;
         digit_ff        <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         debounce_ff  <= debounce_in;
         if (advance) begin
            down_pending_ff <= down_pending_in;
            up_pending_ff   <= up_pending_in;
            down_age_ff     <= down_age_in;
            up_age_ff       <= up_age_in;
            count_ff        <= count_in;
            thousands_ff    <= thousands_in;
            hundreds_ff     <= hundreds_in;
            tens_ff         <= tens_in;
            units_ff        <= units_in;
            scan_pos_ff     <= scan_pos_in;
            segment_ff      <= segment_in;
            digit_ff        <= digit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
   end

   // The decimal digits must always spell the binary count.
   `DUDC_ASSERT(a_digits_match_count, (32'(thousands_ff) * 1000 + 32'(hundreds_ff) * 100 + 32'(tens_ff) * 10 + 32'(units_ff)) == 32'(count_ff), "decimal digits disagree with count")

   // Either all commons are low, as after reset, or exactly one is driven low.
   `DUDC_ASSERT(a_one_common, (digit_ff == 4'd0) || ($countones(digit_ff) == 3), "more than one digit common enabled")

   // The count moves by at most one per transaction.
   `DUDC_ASSERT_SETTLED(a_count_step, (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + 16'd1) || (count_ff == $past(count_ff) - 16'd1), "count moved by more than one")

   // Segments change only on a scan transaction that was processed.
   `DUDC_ASSERT_SETTLED(a_seg_on_scan, $stable(segment_ff) || $past(advance && s1_item_ff.scan_strobe), "segments changed without a scan")

   // A result is produced whenever the input register moves on.
   `DUDC_ASSERT(a_advance_to_rsp, advance |=> rsp_valid_ff, "processed transaction did not reach the result register")

endmodule

[bench/debounced_updown_counter_seg_scan_tb.sv]
// Self-checking testbench for the debounced up/down counter with display scan.
// A directed table and random button sequences are checked against a model in this file;
// depends on dudc_pkg and the debounced_updown_counter_seg_scan RTL.
`timescale 1ns / 1ps

module debounced_updown_counter_seg_scan_tb;

   // Strobe masks, in the bit order of req_item_type.
   localparam logic [6:0] TICK      = 7'b1000000;
   localparam logic [6:0] DOWN_EDGE = 7'b0100000;
   localparam logic [6:0] UP_EDGE   = 7'b0010000;
   localparam logic [6:0] DOWN_LOW  = 7'b0001000;
   localparam logic [6:0] UP_LOW    = 7'b0000100;
   localparam logic [6:0] CHECK     = 7'b0000010;
   localparam logic [6:0] SCAN      = 7'b0000001;

   localparam logic [7:0] AGE_TOP = 8'hFF;
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 280;
   localparam int HOLD_OFF_CYCLES = 120;
   localparam int IDLE_LIMIT      = 4000;

   typedef struct packed {
      logic [7:0]  segments;
      logic [3:0]  digit_enable_n;
      logic [15:0] count_value;
   } display_type;

   typedef struct packed {
      bit          is_cfg;
      logic [7:0]  cfg_ms;
      logic [6:0]  strobes;
      bit          typed;
      display_type shown;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_ms_tick = 1'b0;
   logic req_down_press_edge = 1'b0;
   logic req_up_press_edge = 1'b0;
   logic req_down_pin_low = 1'b0;
   logic req_up_pin_low = 1'b0;
   logic req_check_strobe = 1'b0;
   logic req_scan_strobe = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_segments;
   logic [3:0] rsp_digit_enable_n;
   logic [15:0] rsp_count_value;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [dudc_pkg::DEBOUNCE_WIDTH-1:0] csr_debounce_ms = dudc_pkg::DEBOUNCE_RESET;

   // Model state of the counter and display.
   logic [7:0]   debounce_limit = dudc_pkg::DEBOUNCE_RESET;
   logic [7:0]   down_age_q = '0;
   logic [7:0]   up_age_q = '0;
   bit           down_armed = 1'b0;
   bit           up_armed = 1'b0;
   logic [15:0]  count_q = '0;
   dudc_pkg::scan_pos_type scan_q = dudc_pkg::POS_THOUSANDS;
   logic [7:0]   seg_q = '0;
   logic [3:0]   digit_q = '0;

   display_type displays_owed [$];
   int mismatch_count = 0;
   int idle_cycles = 0;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   bit hold_off_req = 1'b0;
   bit hold_off_served = 1'b0;
   int hold_off_left = 0;

   // Button press being played out by the random generator.
   int unsigned press_ticks_left = 0;
   bit press_down = 1'b0;
   bit press_up = 1'b0;

   debounced_updown_counter_seg_scan u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_ms_tick        (req_ms_tick),
      .req_down_press_edge(req_down_press_edge),
      .req_up_press_edge  (req_up_press_edge),
      .req_down_pin_low   (req_down_pin_low),
      .req_up_pin_low     (req_up_pin_low),
      .req_check_strobe   (req_check_strobe),
      .req_scan_strobe    (req_scan_strobe),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_segments       (rsp_segments),
      .rsp_digit_enable_n (rsp_digit_enable_n),
      .rsp_count_value    (rsp_count_value),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_debounce_ms    (csr_debounce_ms)
   );

   always #4 clock = ~clock;

   function automatic logic [7:0] font_of(input int digit);
      case (digit)
         0:       return 8'h3F;
         1:       return 8'h06;
         2:       return 8'h5B;
         3:       return 8'h4F;
         4:       return 8'h66;
         5:       return 8'h6D;
         6:       return 8'h7D;
         7:       return 8'h07;
         8:       return 8'h7F;
         default: return 8'h6F;
      endcase
   endfunction

   // Applies one transaction to the model: tick, then edges, then check, then scan.
   function automatic display_type next_display(input dudc_pkg::req_item_type it);
      display_type shown;
      int digit;
      if (it.ms_tick) begin
         if (down_age_q != AGE_TOP) down_age_q++;
         if (up_age_q != AGE_TOP) up_age_q++;
      end
      if (it.down_press_edge) begin
         down_age_q = '0;
         down_armed = 1'b1;
      end
      if (it.up_press_edge) begin
         up_age_q = '0;
         up_armed = 1'b1;
      end
      if (it.check_strobe) begin
         if (down_armed && down_age_q > debounce_limit && it.down_pin_low) begin
            count_q--;
            down_armed = 1'b0;
         end
         if (up_armed && up_age_q > debounce_limit && it.up_pin_low) begin
            count_q++;
            up_armed = 1'b0;
         end
      end
      if (it.scan_strobe) begin
         case (scan_q)
            dudc_pkg::POS_THOUSANDS: digit = count_q / 1000;
            dudc_pkg::POS_HUNDREDS:  digit = (count_q / 100) % 10;
            dudc_pkg::POS_TENS:      digit = (count_q / 10) % 10;
            default:                 digit = count_q % 10;
         endcase
         digit_q = ~(4'b0001 << scan_q);
         // A thousands value above nine leaves the segments as they were.
         if (digit <= 9) seg_q = font_of(digit);
         scan_q = scan_q + 1'b1;
      end
      shown.segments = seg_q;
      shown.digit_enable_n = digit_q;
      shown.count_value = count_q;
      return shown;
   endfunction

   // Mostly well-formed presses held long enough to fire, with bounces and noise mixed in.
   function automatic dudc_pkg::req_item_type pick_random_item();
      dudc_pkg::req_item_type it;
      logic [6:0] noise;
      it = '0;
      if ($urandom_range(99) < 15) begin
         noise = 7'($urandom_range(127));
         it = noise;
         return it;
      end
      if (press_ticks_left == 0) begin
         press_down = 1'($urandom_range(1));
         press_up = 1'($urandom_range(1));
         if (!press_down && !press_up) press_down = 1'b1;
         press_ticks_left = debounce_limit + 1 + $urandom_range(3);
         it.down_press_edge = press_down;
         it.up_press_edge = press_up;
         it.scan_strobe = 1'($urandom_range(1));
         return it;
      end
      it.ms_tick = ($urandom_range(9) != 0);
      if (it.ms_tick) press_ticks_left--;
      it.down_pin_low = press_down ^ ($urandom_range(19) == 0);
      it.up_pin_low = press_up ^ ($urandom_range(19) == 0);
      it.check_strobe = (press_ticks_left == 0) || ($urandom_range(3) == 0);
      it.scan_strobe = 1'($urandom_range(1));
      return it;
   endfunction

   function automatic directed_row_type step_row(input logic [6:0] strobes);
      directed_row_type row;
      row = '0;
      row.strobes = strobes;
      return row;
   endfunction

   function automatic directed_row_type typed_row(input logic [6:0] strobes,
         input logic [7:0] segments, input logic [3:0] digits, input logic [15:0] count);
      directed_row_type row;
      row = step_row(strobes);
      row.typed = 1'b1;
      row.shown.segments = segments;
      row.shown.digit_enable_n = digits;
      row.shown.count_value = count;
      return row;
   endfunction

   function automatic directed_row_type cfg_row(input logic [7:0] ms);
      directed_row_type row;
      row = '0;
      row.is_cfg = 1'b1;
      row.cfg_ms = ms;
      return row;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch in %s: got 0x%0h, expected 0x%0h", what, got, want);
      mismatch_count++;
   endtask

   // Offers one transaction and returns at the edge where it is accepted.
   task automatic send_item(input dudc_pkg::req_item_type it);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ms_tick <= it.ms_tick;
      req_down_press_edge <= it.down_press_edge;
      req_up_press_edge <= it.up_press_edge;
      req_down_pin_low <= it.down_pin_low;
      req_up_pin_low <= it.up_pin_low;
      req_check_strobe <= it.check_strobe;
      req_scan_strobe <= it.scan_strobe;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_displays();
      req_valid <= 1'b0;
      while (displays_owed.size() != 0) @(posedge clock);
   endtask

   // The register is only written once the pipeline has emptied.
   task automatic write_debounce(input logic [7:0] ms);
      drain_displays();
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_debounce_ms <= ms;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      debounce_limit = ms;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_off_left <= 0;
      end else if (hold_off_left != 0) begin
         rsp_stall <= 1'b1;
         hold_off_left <= hold_off_left - 1;
      end else if (hold_off_req && !hold_off_served) begin
         rsp_stall <= 1'b1;
         hold_off_left <= HOLD_OFF_CYCLES;
         hold_off_served <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      display_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (displays_owed.size() == 0) begin
            report_mismatch("unexpected transaction count_value", 32'(rsp_count_value), 0);
         end else begin
            want = displays_owed.pop_front();
            if (rsp_segments !== want.segments)
               report_mismatch("segments", 32'(rsp_segments), 32'(want.segments));
            if (rsp_digit_enable_n !== want.digit_enable_n)
               report_mismatch("digit_enable_n", 32'(rsp_digit_enable_n),
                               32'(want.digit_enable_n));
            if (rsp_count_value !== want.count_value)
               report_mismatch("count_value", 32'(rsp_count_value), 32'(want.count_value));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
            || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      directed_row_type directed_rows [$];
      directed_row_type row;
      display_type want;
      dudc_pkg::req_item_type it;
      logic [7:0] ms;

      // After reset, the first scan shows a zero on the thousands digit.
      directed_rows.push_back(typed_row(7'b0, 8'h00, 4'h0, 16'h0000));
      directed_rows.push_back(typed_row(SCAN, 8'h3F, 4'hE, 16'h0000));
      // One millisecond is not above the reset limit of fifty.
      directed_rows.push_back(step_row(DOWN_EDGE));
      directed_rows.push_back(step_row(TICK | CHECK | DOWN_LOW));
      directed_rows.push_back(cfg_row(8'd0));
      // Decrement from zero wraps to the top of the count.
      directed_rows.push_back(typed_row(TICK | CHECK | DOWN_LOW, 8'h3F, 4'hE, 16'hFFFF));
      directed_rows.push_back(step_row(SCAN));
      directed_rows.push_back(step_row(SCAN));
      directed_rows.push_back(step_row(SCAN));
      // Thousands value 65 keeps the old segments while the commons move on.
      directed_rows.push_back(typed_row(SCAN, 8'h6D, 4'hE, 16'hFFFF));
      directed_rows.push_back(step_row(UP_EDGE | CHECK | UP_LOW));
      directed_rows.push_back(typed_row(TICK | CHECK | UP_LOW | SCAN, 8'h3F, 4'hD, 16'h0000));
      // Both buttons firing in one check cancel out.
      directed_rows.push_back(step_row(DOWN_EDGE | UP_EDGE));
      directed_rows.push_back(step_row(TICK | CHECK | DOWN_LOW | UP_LOW));
      directed_rows.push_back(step_row(TICK | CHECK | DOWN_LOW | UP_LOW));
      // A released pin blocks the fire, which then happens once the pin is low again.
      directed_rows.push_back(step_row(DOWN_EDGE));
      directed_rows.push_back(step_row(TICK | CHECK));
      directed_rows.push_back(step_row(TICK | CHECK | DOWN_LOW));
      directed_rows.push_back(step_row(7'h7F));
      directed_rows.push_back(cfg_row(8'd255));
      directed_rows.push_back(step_row(TICK | CHECK | DOWN_LOW | UP_LOW));
      directed_rows.push_back(cfg_row(8'd254));
      directed_rows.push_back(step_row(TICK | CHECK | DOWN_LOW | UP_LOW | SCAN));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_cfg) begin
            write_debounce(row.cfg_ms);
         end else begin
            it = row.strobes;
            send_item(it);
            want = next_display(it);
            if (row.typed) want = row.shown;
            displays_owed.push_back(want);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       ms = 8'd50;
            1:       ms = 8'd0;
            2:       ms = 8'd254;
            3:       ms = 8'd255;
            4:       ms = 8'd1;
            default: ms = 8'($urandom_range(2, 20));
         endcase
         write_debounce(ms);
         if (p < 2) begin
            tx_idle_pct = 32;
            rx_idle_pct <= 79;
         end else if (p < 4) begin
            tx_idle_pct = 79;
            rx_idle_pct <= 32;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct <= 0;
         end
         // With no idling, a long receiver hold-off backs the block up into its input.
         if (p == 4) hold_off_req <= 1'b1;
         press_ticks_left = 0;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (p == PHASES - 1 && n == ITEMS_PER_PHASE / 2) drain_displays();
            it = pick_random_item();
            send_item(it);
            displays_owed.push_back(next_display(it));
         end
      end

      drain_displays();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+hdl
hdl/dudc_pkg.sv
hdl/debounced_updown_counter_seg_scan.sv
bench/debounced_updown_counter_seg_scan_tb.sv
